### src/gpi_pkg.sv
// gpi_pkg: shared types, constants and the length-to-step table of the
// golden prime interleaver
// no dependencies
package gpi_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODE         = CFG_IDX_W'(1);

  // field widths fixed by the interface
  localparam int CFG_LEN_W  = 12;
  localparam int STEP_W     = 12;
  localparam int OUT_DATA_W = 32;

  // reset values of the frame settings
  localparam int LEN_RESET  = 112;
  localparam int STEP_RESET = 71;

  // mode codes
  localparam logic MODE_INTERLEAVE   = 1'b0;
  localparam logic MODE_DEINTERLEAVE = 1'b1;

  // depth of the output queue
  localparam int OUT_DEPTH = 3;

  // frame length to step table
  localparam int TAB_N = 21;
  localparam logic [CFG_LEN_W-1:0] LEN_TAB [0:TAB_N-1] = '{
    12'd112,  12'd210,  12'd224,  12'd252,  12'd420,  12'd448,  12'd504,
    12'd672,  12'd896,  12'd1120, 12'd1344, 12'd1568, 12'd1792, 12'd2016,
    12'd2240, 12'd2464, 12'd2688, 12'd2912, 12'd3136, 12'd3360, 12'd3584
  };
  localparam logic [STEP_W-1:0] STEP_TAB [0:TAB_N-1] = '{
    12'd71,   12'd131,  12'd139,  12'd157,  12'd263,  12'd277,  12'd313,
    12'd419,  12'd557,  12'd701,  12'd839,  12'd971,  12'd1109, 12'd1249,
    12'd1399, 12'd1523, 12'd1663, 12'd1801, 12'd1949, 12'd2081, 12'd2213
  };

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              hit;
  } step_lookup_t;

  // per-transaction read side info from the address generator
  typedef struct packed {
    logic rd_en;   // previous frame is stored, a result is due
    logic last;    // last element of the frame
    logic err;     // length not in table
  } gpi_rd_info_t;

  // full table search, last match wins
  function automatic step_lookup_t step_lookup(input logic [CFG_LEN_W-1:0] len);
    step_lookup_t res;
    res.step = '0;
    res.hit  = 1'b0;
    for (int k = 0; k < TAB_N; k++) begin
      if (LEN_TAB[k] == len) begin
        res.step = STEP_TAB[k];
        res.hit  = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

### src/golden_prime_interleaver_top.sv
// golden_prime_interleaver_top: frame interleaver / deinterleaver with a
// ping-pong frame store; depends on gpi_pkg, gpi_ctrl, gpi_ram, gpi_out_fifo
//
// Usage:
//  - in_* carries one element word per transaction. Elements of frame k are
//    written into one bank while frame k-1 is read from the other bank, so
//    each accepted element after the first full frame produces one result.
//  - out_* carries the permuted element of the previous frame; out_tlast
//    marks the last element of an output frame, out_tuser flags a frame
//    length that is not in the step table (identity order used).
//  - cfg_* writes frame_length (index 0) and mode (index 1). Settings are
//    taken at the first element of each frame; write only while idle.
//  - Throughput: one element per cycle while the output queue has room, set
//    by the combinational modular address add and one write plus one read
//    port on the frame memory. A result passes through the registered memory
//    read, then the output queue, before it is shown on out_*.
//  - Reset clears all control state; memory contents stay undefined and no
//    result is given until one full frame has been stored.
//  - When out_tready is low, a three-entry output queue absorbs results and
//    in_tready drops once it would overflow.
module golden_prime_interleaver_top import gpi_pkg::*; #(
  parameter int MAX_FRAME  = 4096,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // [31:0] in_data
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [31:0] out_data
  output logic                  out_tlast,  // frame_end
  output logic                  out_tuser   // [0] length_error
);

  localparam int AW        = $clog2(MAX_FRAME);
  localparam int RAM_DEPTH = 2 * (1 << AW);
  localparam int STORE_W   = (DATA_WIDTH < OUT_DATA_W) ? DATA_WIDTH : OUT_DATA_W;
  localparam int Q_W       = STORE_W + 2;
  localparam int CW        = $clog2(OUT_DEPTH + 1);

  logic               accept, cfg_we;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic               wr_bank, rd_bank;
  gpi_rd_info_t       info;
  logic [STORE_W-1:0] rd_data;
  logic [Q_W-1:0]     head_data;
  logic [CW-1:0]      q_count;
  logic               s1_valid_r, s1_last_r, s1_err_r;

  assign cfg_ready = rst_n;
  assign cfg_we    = cfg_valid && cfg_ready;

  // room for the read in flight plus a new one keeps one item per cycle while results are taken
  assign in_tready = rst_n && (({1'b0, q_count} + (CW+1)'(s1_valid_r)) <= (CW+1)'(2));
  assign accept    = in_tvalid && in_tready;

  gpi_ctrl #(
    .MAX_FRAME (MAX_FRAME)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .wr_bank   (wr_bank),
    .rd_bank   (rd_bank),
    .info      (info)
  );

  // read and write always hit opposite banks, so no forwarding is needed
  gpi_ram #(
    .WIDTH (STORE_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr ({wr_bank, wr_addr}),
    .wdata (in_tdata[STORE_W-1:0]),
    .re    (accept && info.rd_en),
    .raddr ({rd_bank, rd_addr}),
    .rdata (rd_data)
  );

  // result tags are registered alongside the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept && info.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r <= info.last;
      s1_err_r  <= info.err;
    end
  end

  gpi_out_fifo #(
    .WIDTH (Q_W)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_valid_r),
    .push_data  ({s1_err_r, s1_last_r, rd_data}),
    .pop        (out_tready),
    .head_valid (out_tvalid),
    .head_data  (head_data),
    .count      (q_count)
  );

  assign out_tdata = OUT_DATA_W'(head_data[STORE_W-1:0]);
  assign out_tlast = head_data[STORE_W];
  assign out_tuser = head_data[STORE_W+1];

endmodule

### src/gpi_ram.sv
// gpi_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module gpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/gpi_ctrl.sv
// gpi_ctrl: configuration registers, per-frame latch and the incremental
// permuted address generator; depends on gpi_pkg
module gpi_ctrl import gpi_pkg::*; #(
  parameter int MAX_FRAME = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         accept,
  output logic [$clog2(MAX_FRAME)-1:0] wr_addr,
  output logic [$clog2(MAX_FRAME)-1:0] rd_addr,
  output logic                         wr_bank,
  output logic                         rd_bank,
  output gpi_rd_info_t                 info
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int LW = AW + 1;
  localparam logic [CFG_LEN_W:0] MAX_LEN_C = (CFG_LEN_W+1)'(MAX_FRAME);

  logic [CFG_LEN_W-1:0] frame_length_r;
  logic                 mode_r;

  logic [AW-1:0] cnt_r, perm_r, act_step_r;
  logic [LW-1:0] act_len_r;
  logic          act_mode_r, act_err_r, bank_r, ready_r;

  step_lookup_t  lk;
  logic [LW-1:0] new_len, eff_len, sum;
  logic [AW-1:0] new_step, eff_step, perm_step;
  logic          new_err, eff_err, eff_mode, first, last;

  // frame settings as latched at the first element of a frame
  always_comb begin
    lk = step_lookup(frame_length_r);
    if ({1'b0, frame_length_r} > MAX_LEN_C) begin
      new_len  = LW'(MAX_FRAME);
      new_step = AW'(1);
      new_err  = 1'b1;
    end else if (lk.hit) begin
      new_len  = LW'(frame_length_r);
      new_step = AW'(lk.step);
      new_err  = 1'b0;
    end else begin
      new_len  = (frame_length_r == '0) ? LW'(1) : LW'(frame_length_r);
      new_step = AW'(1);
      new_err  = 1'b1;
    end
  end

  assign first    = (cnt_r == '0);
  assign eff_len  = first ? new_len  : act_len_r;
  assign eff_step = first ? new_step : act_step_r;
  assign eff_err  = first ? new_err  : act_err_r;
  assign eff_mode = first ? mode_r   : act_mode_r;

  // address selection by mode
  assign wr_addr = (eff_mode == MODE_DEINTERLEAVE) ? cnt_r  : perm_r;
  assign rd_addr = (eff_mode == MODE_DEINTERLEAVE) ? perm_r : cnt_r;
  assign wr_bank = bank_r;
  assign rd_bank = ~bank_r;

  assign last = (({1'b0, cnt_r} + LW'(1)) >= eff_len);

  // j += b mod N, one conditional subtract since j and b are below N
  assign sum       = {1'b0, perm_r} + {1'b0, eff_step};
  assign perm_step = (sum >= eff_len) ? AW'(sum - eff_len) : AW'(sum);

  assign info.rd_en = ready_r;
  assign info.last  = last;
  assign info.err   = eff_err;

  // configuration and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= CFG_LEN_W'(LEN_RESET);
      mode_r         <= MODE_INTERLEAVE;
      cnt_r          <= '0;
      perm_r         <= '0;
      act_step_r     <= AW'(STEP_RESET);
      act_len_r      <= LW'(LEN_RESET);
      act_mode_r     <= MODE_INTERLEAVE;
      act_err_r      <= 1'b0;
      bank_r         <= 1'b0;
      ready_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_LENGTH: frame_length_r <= cfg_data;
          REG_MODE:         mode_r         <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        if (first) begin
          act_len_r  <= new_len;
          act_step_r <= new_step;
          act_err_r  <= new_err;
          act_mode_r <= mode_r;
        end
        if (last) begin
          cnt_r   <= '0;
          perm_r  <= '0;
          bank_r  <= ~bank_r;
          ready_r <= 1'b1;
        end else begin
          cnt_r  <= cnt_r + AW'(1);
          perm_r <= perm_step;
        end
      end
    end
  end

endmodule

### src/gpi_out_fifo.sv
// gpi_out_fifo: small output queue that decouples the result channel from
// the input side; depends on gpi_pkg
module gpi_out_fifo import gpi_pkg::*; #(
  parameter int WIDTH = 34
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic [WIDTH-1:0]                 push_data,
  input  logic                             pop,
  output logic                             head_valid,
  output logic [WIDTH-1:0]                 head_data,
  output logic [$clog2(OUT_DEPTH+1)-1:0]   count
);

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic [WIDTH-1:0] entry_r [0:OUT_DEPTH-1];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign count      = count_r;

  // payload entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({push, do_pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### src/gpi_checker.sv
// gpi_checker: port-level checks of the interleaver top, attached by bind
// depends on golden_prime_interleaver_top
module gpi_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [31:0]           out_tdata,
  input logic                  out_tlast,
  input logic                  out_tuser
);

  // reset empties the output queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // a rise of out_tvalid follows an input transaction, through the memory read register and the output queue
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching input transaction");

  // the input side only stalls while results are waiting
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind golden_prime_interleaver_top gpi_checker u_gpi_checker (.*);

### tb/golden_prime_interleaver_checker.sv
`timescale 1ns / 100ps
// golden_prime_interleaver_checker: watches the config, input and result
// channels, predicts every result and compares it field by field
// depends on gpi_pkg for port widths, register indexes, mode codes and reset values
module golden_prime_interleaver_checker import gpi_pkg::*; #(
  parameter int MAX_FRAME = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [31:0]           in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [31:0]           out_tdata,
  input  logic                  out_tlast,
  input  logic                  out_tuser,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [31:0] word;
    logic        frame_end;
    logic        length_error;
  } element_result_t;

  // two banks, the one being filled and the one being read out
  logic [31:0] frame_words [0:2*MAX_FRAME-1];

  // register settings as last written
  logic [CFG_LEN_W-1:0] len_setting;
  logic                 mode_setting;

  // per-frame state, latched at the first element
  int   element_idx;
  int   hop_addr;
  int   hop;
  int   cur_len;
  logic cur_mode;
  logic cur_err;
  logic fill_bank;
  logic have_frame;

  element_result_t due_results [$];
  element_result_t want;

  // one input element: queue the result it causes, store it, advance
  task automatic interleave_element(input logic [31:0] word);
    element_result_t res;
    int wr_addr;
    int rd_addr;
    int wbase;
    int rbase;
    int nxt;
    logic at_end;

    // latch length, step and mode at the frame start
    if (element_idx == 0) begin
      case (len_setting)
        12'd112:  hop = 71;
        12'd210:  hop = 131;
        12'd224:  hop = 139;
        12'd252:  hop = 157;
        12'd420:  hop = 263;
        12'd448:  hop = 277;
        12'd504:  hop = 313;
        12'd672:  hop = 419;
        12'd896:  hop = 557;
        12'd1120: hop = 701;
        12'd1344: hop = 839;
        12'd1568: hop = 971;
        12'd1792: hop = 1109;
        12'd2016: hop = 1249;
        12'd2240: hop = 1399;
        12'd2464: hop = 1523;
        12'd2688: hop = 1663;
        12'd2912: hop = 1801;
        12'd3136: hop = 1949;
        12'd3360: hop = 2081;
        12'd3584: hop = 2213;
        default:  hop = 0;
      endcase
      // unknown length: identity order
      cur_err = (hop == 0);
      if (cur_err) hop = 1;
      // a 12-bit length never exceeds the store, zero acts as one
      cur_len  = (len_setting == 0) ? 1 : int'(len_setting);
      cur_mode = mode_setting;
      hop_addr = 0;
    end

    if (cur_mode == MODE_INTERLEAVE) begin
      wr_addr = hop_addr;
      rd_addr = element_idx;
    end else begin
      wr_addr = element_idx;
      rd_addr = hop_addr;
    end
    wbase  = fill_bank ? MAX_FRAME : 0;
    rbase  = fill_bank ? 0 : MAX_FRAME;
    at_end = (element_idx + 1 >= cur_len);

    if (have_frame) begin
      res.word         = frame_words[rbase + rd_addr];
      res.frame_end    = at_end;
      res.length_error = cur_err;
      due_results.push_back(res);
    end
    frame_words[wbase + wr_addr] = word;

    // next element or swap banks
    if (at_end) begin
      element_idx = 0;
      hop_addr    = 0;
      fill_bank   = ~fill_bank;
      have_frame  = 1'b1;
    end else begin
      element_idx++;
      nxt = hop_addr + hop;
      if (nxt >= cur_len) nxt -= cur_len;
      hop_addr = nxt;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      len_setting  = CFG_LEN_W'(LEN_RESET);
      mode_setting = MODE_INTERLEAVE;
      element_idx  = 0;
      hop_addr     = 0;
      hop          = STEP_RESET;
      cur_len      = LEN_RESET;
      cur_mode     = MODE_INTERLEAVE;
      cur_err      = 1'b0;
      fill_bank    = 1'b0;
      have_frame   = 1'b0;
      fail_count   = 0;
      due_results.delete();
    end else begin
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_LENGTH: len_setting = cfg_data;
          REG_MODE:         mode_setting = cfg_data[0];
          default:          ;
        endcase
      end

      // result transaction against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("result with nothing expected: out_data %h", out_tdata);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_tdata !== want.word) begin
            $error("out_data: expected %h, actual %h", want.word, out_tdata);
            fail_count++;
          end
          if (out_tlast !== want.frame_end) begin
            $error("frame_end: expected %b, actual %b", want.frame_end, out_tlast);
            fail_count++;
          end
          if (out_tuser !== want.length_error) begin
            $error("length_error: expected %b, actual %b", want.length_error, out_tuser);
            fail_count++;
          end
        end
      end

      // input transaction
      if (in_tvalid && in_tready) interleave_element(in_tdata);
    end
    pending = due_results.size();
  end

endmodule

### tb/golden_prime_interleaver_top_test.sv
`timescale 1ns / 100ps
// golden_prime_interleaver_top_test: stimulus, flow control and verdict for
// the interleaver; depends on gpi_pkg, the RTL and the checker module
module golden_prime_interleaver_top_test;
  import gpi_pkg::*;

  // indexes that hold no register, written to see them ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);
  localparam int PREFILL_LEN  = 252;   // largest length in use after the fill
  localparam int RANDOM_ITEMS = 600;
  localparam int SETTLE       = 8;

  logic                  clk = 1'b0, rst_n = 1'b0;
  logic                  cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0, in_tready;
  logic [31:0]           in_tdata = '0;
  logic                  out_tvalid, out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic                  out_tlast, out_tuser;

  int fail_count;
  int pending;
  bit send_gaps;
  bit sink_gaps;
  int sent;
  int settings;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  golden_prime_interleaver_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  golden_prime_interleaver_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // wait until every expected result is out, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // length and mode write, optionally preceded by a write to a spare index
  task automatic program_frame(input int len, input logic mode, input bit stray);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    cfg_valid <= 1'b1;
    if (stray) begin
      cfg_index <= ($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI;
      cfg_data  <= CFG_DATA_W'($urandom);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_index <= REG_FRAME_LENGTH;
    cfg_data  <= CFG_DATA_W'(len);
    do @(posedge clk); while (!cfg_ready);
    // upper bits of the mode word carry noise
    cfg_index <= REG_MODE;
    cfg_data  <= {noise[CFG_DATA_W-1:1], mode};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // one element transaction; valid stays high when no gap follows
  task automatic send_element(input logic [31:0] word);
    int gap;
    gap = send_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic send_elements(input int count);
    for (int k = 0; k < count; k++) send_element($urandom);
    in_tvalid <= 1'b0;
  endtask

  // result sink with a random stall before each transaction while sink_gaps is set
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = sink_gaps ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int len;
    int span;
    int count;
    int pick;
    int random_sent;

    sent = 0;
    settings = 0;
    random_sent = 0;
    send_gaps = 1'b0;
    sink_gaps = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // two full frames at the largest length in use so that every address
    // of both banks that is read later holds data
    settle();
    program_frame(PREFILL_LEN, MODE_INTERLEAVE, 1'b1);
    send_elements(PREFILL_LEN);
    settle();
    program_frame(PREFILL_LEN, MODE_DEINTERLEAVE, 1'b0);
    send_elements(PREFILL_LEN);

    // zero length: one-element frames, data extremes
    send_gaps = 1'b1;
    sink_gaps = 1'b1;
    settle();
    program_frame(0, MODE_INTERLEAVE, 1'b0);
    send_element(32'h0000_0000);
    send_element(32'hFFFF_FFFF);
    send_element(32'hA5A5_5A5A);
    in_tvalid <= 1'b0;

    // tiny lengths outside the table in both modes
    settle();
    program_frame(1, MODE_DEINTERLEAVE, 1'b1);
    send_element(32'hFFFF_FFFF);
    send_element(32'h0000_0000);
    in_tvalid <= 1'b0;
    settle();
    program_frame(2, MODE_INTERLEAVE, 1'b0);
    send_elements(4);
    settle();
    program_frame(3, MODE_DEINTERLEAVE, 1'b0);
    send_elements(6);

    // shortest table length, interleave then deinterleave
    settle();
    program_frame(112, MODE_INTERLEAVE, 1'b0);
    send_elements(112);
    settle();
    program_frame(112, MODE_DEINTERLEAVE, 1'b0);
    send_elements(112);

    // random settings; phases may end mid-frame so writes land mid-frame
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        case ($urandom_range(0, 3))
          0:       len = 112;
          1:       len = 210;
          2:       len = 224;
          default: len = 252;
        endcase
      end else if (pick < 62) begin
        // one off a table entry
        len = ($urandom_range(0, 1) == 0) ? 111 : 113;
        if ($urandom_range(0, 1) == 0) len += 98;
      end else begin
        len = $urandom_range(0, 40);
      end
      send_gaps = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      program_frame(len, 1'($urandom_range(0, 1)), ($urandom_range(0, 9) == 0));
      span = (len == 0) ? 1 : len;
      if ($urandom_range(0, 4) != 0) count = span * $urandom_range(1, 2);
      else count = $urandom_range(1, span);
      send_elements(count);
      random_sent += count;
    end

    settle();
    $display("%0d elements sent under %0d frame settings, lengths 0 to %0d, both modes",
             sent, settings, PREFILL_LEN);
    $display("random lengths in and out of the table, mid-frame setting changes, random stalls");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
src/gpi_pkg.sv
src/gpi_ram.sv
src/gpi_ctrl.sv
src/gpi_out_fifo.sv
src/golden_prime_interleaver_top.sv
src/gpi_checker.sv
tb/golden_prime_interleaver_checker.sv
tb/golden_prime_interleaver_top_test.sv
